FILE: rtl/iss_pkg.sv
`timescale 1ns / 1ps

package iss_pkg;

    // Store geometry
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Port widths
    localparam int ACT_W  = 2;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // Count value of a full store
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(CAPACITY);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } iss_cmd_t;

endpackage

FILE: rtl/iss_ctrl.sv
`timescale 1ns / 1ps

module iss_ctrl
    import iss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output iss_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Decode next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next = cmd.execute;

    // Hold state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

    // Result strobe follows exactly one execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.execute))
        else $error("result strobe without execute");

    // A strobe is never followed by another strobe
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

    // Every captured request goes on to execute
    a_exec_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("captured request not executed");

endmodule

FILE: rtl/iss_datapath.sv
`timescale 1ns / 1ps

module iss_datapath
    import iss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  iss_cmd_t          cmd,
    input  logic [ACT_W-1:0]  action,
    input  logic [IDX_W-1:0]  index,
    input  logic [VAL_W-1:0]  value,
    output logic [VAL_W-1:0]  read_value,
    output logic [STAT_W-1:0] status,
    output logic [CNT_W-1:0]  count
);

    // Request registers
    logic [ACT_W-1:0]      act_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    // Entry chain and count
    logic [DATA_WIDTH-1:0] entry_reg [CAPACITY];
    logic [CNT_W-1:0]      count_reg, count_next;

    // Result registers
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic [STAT_W-1:0]     stat_reg, stat_next;

    logic                  in_range;
    logic                  is_full;
    logic [IDX_W-1:0]      tail_idx;
    logic [DATA_WIDTH-1:0] sel_word;

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            idx_reg <= index;
            val_reg <= DATA_WIDTH'(value);
        end
    end

    assign in_range = ({1'b0, idx_reg} < count_reg);
    assign is_full  = (count_reg >= COUNT_FULL);
    assign tail_idx = count_reg[IDX_W-1:0];
    assign sel_word = entry_reg[idx_reg];

    // Decode the action into result and new count
    always_comb
    begin
        rd_next    = '0;
        stat_next  = STAT_OK;
        count_next = count_reg;
        unique case (act_reg)
            ACT_APPEND:
            begin
                if (is_full)
                    stat_next = STAT_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            ACT_GET:
            begin
                if (!in_range)
                    stat_next = STAT_RANGE;
                else
                    rd_next = sel_word;
            end
            ACT_SET:
            begin
                if (!in_range)
                    stat_next = STAT_RANGE;
            end
            ACT_REMOVE:
            begin
                if (!in_range)
                    stat_next = STAT_RANGE;
                else
                begin
                    rd_next    = sel_word;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                stat_next = STAT_OK;
            end
        endcase
    end

    // Update each cell: load, overwrite or take the next cell's word
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (cmd.execute)
            begin
                if (act_reg == ACT_APPEND && !is_full && tail_idx == IDX_W'(k))
                    entry_reg[k] <= val_reg;
                else if (act_reg == ACT_SET && in_range && idx_reg == IDX_W'(k))
                    entry_reg[k] <= val_reg;
                else if (act_reg == ACT_REMOVE && in_range && k < CAPACITY - 1
                         && IDX_W'(k) >= idx_reg
                         && CNT_W'(k + 1) < count_reg)
                    entry_reg[k] <= entry_reg[(k + 1) % CAPACITY];
            end
        end
    end

    // Register the result
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rd_reg   <= rd_next;
            stat_reg <= stat_next;
        end
    end

    // Hold the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.execute)
            count_reg <= count_next;
    end

    assign read_value = VAL_W'(rd_reg);
    assign status     = stat_reg;
    assign count      = count_reg;

    // Count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("entry count beyond capacity");

    // Count moves only on execute
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> $stable(count_reg))
        else $error("entry count changed without execute");

    // A full status leaves the count at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && act_reg == ACT_APPEND && is_full |=>
            stat_reg == STAT_FULL && count_reg == COUNT_FULL)
        else $error("append on full store changed count");

endmodule

FILE: rtl/indexed_sequence_store.sv
`timescale 1ns / 1ps

// Channel   Handshake            Ports
// request   start && !busy       action, index, value
// result    done (one cycle)     read_value, status, count
//
// Each request is first latched into the request registers, then run through
// the chain of entry cells, where a removal shifts every later cell down.
// The result shows for one cycle after the execute cycle, and the next
// request is accepted in that same cycle; no new request is taken while busy.
// Reset clears the entry count and the controller; entries are not cleared.
// The receiver cannot stall: done lasts exactly one cycle.

module indexed_sequence_store
    import iss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  action,
    input  logic [IDX_W-1:0]  index,
    input  logic [VAL_W-1:0]  value,
    output logic              done,
    output logic [VAL_W-1:0]  read_value,
    output logic [STAT_W-1:0] status,
    output logic [CNT_W-1:0]  count
);

    iss_cmd_t cmd;

    iss_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    iss_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .action     (action),
        .index      (index),
        .value      (value),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

endmodule
